### sv/circular_double_ended_queue_macros.svh
// assertion macros used by the checker file
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/cdq_pkg.sv
// shared types and constants of the circular double-ended queue
package cdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int OCC_W          = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller to datapath strobes
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } cdq_ctl_t;

endpackage

### sv/cdq_ctrl.sv
// controller state machine: input handshake, sequencing and output valid
module cdq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output cdq_pkg::cdq_ctl_t ctl
);
    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // strobes to the datapath
    always_comb
    begin
        cmd_ready   = (state_reg == S_IDLE);
        ctl.capture = cmd_valid && (state_reg == S_IDLE);
        ctl.execute = (state_reg == S_EXEC);
        ctl.load    = (state_reg == S_RESULT) && (!rsp_valid_reg || rsp_ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
                state_next = S_RESULT;
            S_RESULT:
            begin
                if (ctl.load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // output word valid: set on load, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### sv/cdq_datapath.sv
// datapath: pointers, count, slot memory and output registers
module cdq_datapath #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cdq_pkg::cdq_ctl_t                     ctl,
    input  logic        [cdq_pkg::CMD_W-1:0]      command,
    input  logic signed [cdq_pkg::VALUE_W-1:0]    value,
    output logic        [cdq_pkg::STATUS_W-1:0]   status,
    output logic signed [cdq_pkg::VALUE_W-1:0]    read_data,
    output logic        [cdq_pkg::OCC_W-1:0]      occupancy,
    output logic                                  is_full,
    output logic                                  is_empty
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_ONES = 2'd1,
        RD_MEM  = 2'd2
    } rd_sel_t;

    // control state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // captured word and pending result
    logic [CMD_W-1:0]        cmd_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    rd_sel_t                 res_sel_reg, res_sel_next;

    // slot memory
    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic [DATA_WIDTH-1:0]   rd_data_reg;
    logic                    wr_en;
    logic [PTR_W-1:0]        wr_addr;
    logic [PTR_W-1:0]        rd_addr;
    logic [DATA_WIDTH+VALUE_W-1:0] wr_ext;
    logic [DATA_WIDTH-1:0]   wr_word;
    logic [VALUE_W+DATA_WIDTH-1:0] rd_ext;
    logic [OCC_W+CNT_W-1:0]  occ_ext;

    // output registers
    logic [STATUS_W-1:0]     status_reg;
    logic [VALUE_W-1:0]      read_data_reg;
    logic [OCC_W-1:0]        occupancy_reg;
    logic                    is_full_reg;
    logic                    is_empty_reg;

    // width fitting of stored and returned words
    assign wr_ext  = {{DATA_WIDTH{1'b0}}, value_reg};
    assign wr_word = wr_ext[DATA_WIDTH-1:0];
    assign rd_ext  = {{VALUE_W{1'b0}}, rd_data_reg};
    assign occ_ext = {{OCC_W{1'b0}}, count_reg};

    // command decode and pointer update
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        res_status_next = ST_DONE;
        res_sel_next    = RD_ZERO;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        rd_addr         = head_reg;
        case (cmd_reg)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (count_reg == CNT_W'(DEPTH))
                    res_status_next = ST_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == '0)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end
                    else if (cmd_reg == CMD_PUSH_FRONT)
                    begin
                        head_next = head_reg - PTR_W'(1);
                        wr_addr   = head_next;
                    end
                    else
                    begin
                        tail_next = tail_reg + PTR_W'(1);
                        wr_addr   = tail_next;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (count_reg == '0)
                    res_status_next = ST_EMPTY;
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    // last word leaves the pointers where they are
                    if (count_reg > CNT_W'(1))
                    begin
                        if (cmd_reg == CMD_POP_FRONT)
                            head_next = head_reg + PTR_W'(1);
                        else
                            tail_next = tail_reg - PTR_W'(1);
                    end
                end
            end
            CMD_PEEK_FRONT, CMD_PEEK_REAR:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                    res_sel_next    = RD_ONES;
                end
                else
                begin
                    res_sel_next = RD_MEM;
                    rd_addr      = (cmd_reg == CMD_PEEK_FRONT) ? head_reg : tail_reg;
                end
            end
            default:
            begin
                res_status_next = ST_DONE;
            end
        endcase
    end

    // pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctl.execute)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // input word capture and pending result
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= command;
            value_reg <= value;
        end
        if (ctl.execute)
        begin
            res_status_reg <= res_status_next;
            res_sel_reg    <= res_sel_next;
        end
    end

    // slot memory write port
    always_ff @(posedge clk)
    begin
        if (ctl.execute && wr_en)
            mem[wr_addr] <= wr_word;
    end

    // slot memory registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.execute)
            rd_data_reg <= mem[rd_addr];
    end

    // output word load
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            status_reg    <= res_status_reg;
            occupancy_reg <= occ_ext[OCC_W-1:0];
            is_full_reg   <= (count_reg == CNT_W'(DEPTH));
            is_empty_reg  <= (count_reg == '0);
            case (res_sel_reg)
                RD_ZERO: read_data_reg <= '0;
                RD_ONES: read_data_reg <= '1;
                RD_MEM:  read_data_reg <= rd_ext[VALUE_W-1:0];
                default: read_data_reg <= '0;
            endcase
        end
    end

    assign status    = status_reg;
    assign read_data = read_data_reg;
    assign occupancy = occupancy_reg;
    assign is_full   = is_full_reg;
    assign is_empty  = is_empty_reg;

endmodule

### sv/circular_double_ended_queue.sv
// top level of the circular double-ended queue
//
//   channel   handshake               payload
//   cmd       cmd_valid / cmd_ready   command, value
//   rsp       rsp_valid / rsp_ready   status, read_data, occupancy, is_full, is_empty
//
// one command passes through capture, execute against pointers and the
// slot memory, then load of the output register (peek data comes from the
// registered memory read port issued during execute)
// a new command is taken while the previous word waits in the output register
// reset clears pointers, count and valids; slot contents are undefined until written
// a stalled output holds the load step until the output register frees up
module circular_double_ended_queue #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  logic        [cdq_pkg::CMD_W-1:0]      command,
    input  logic signed [cdq_pkg::VALUE_W-1:0]    value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic        [cdq_pkg::STATUS_W-1:0]   status,
    output logic signed [cdq_pkg::VALUE_W-1:0]    read_data,
    output logic        [cdq_pkg::OCC_W-1:0]      occupancy,
    output logic                                  is_full,
    output logic                                  is_empty
);
    import cdq_pkg::*;

    cdq_ctl_t ctl;

    // sequencing and handshakes
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctl       (ctl)
    );

    // queue state and result
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .command   (command),
        .value     (value),
        .status    (status),
        .read_data (read_data),
        .occupancy (occupancy),
        .is_full   (is_full),
        .is_empty  (is_empty)
    );

endmodule

### sv/cdq_checker.sv
// port-level checker of the circular double-ended queue and its bind
`include "circular_double_ended_queue_macros.svh"

module cdq_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  cmd_valid,
    input logic                                  cmd_ready,
    input logic        [cdq_pkg::CMD_W-1:0]      command,
    input logic signed [cdq_pkg::VALUE_W-1:0]    value,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic        [cdq_pkg::STATUS_W-1:0]   status,
    input logic signed [cdq_pkg::VALUE_W-1:0]    read_data,
    input logic        [cdq_pkg::OCC_W-1:0]      occupancy,
    input logic                                  is_full,
    input logic                                  is_empty
);
    import cdq_pkg::*;

    // full and empty flags exclude each other
    `CDQ_ASSERT_NOW(a_flags_excl, clk, rst_n, rsp_valid, !(is_full && is_empty))

    // a waiting input word holds until taken
    `CDQ_ASSERT_NEXT(a_cmd_hold, clk, rst_n, cmd_valid && !cmd_ready, cmd_valid && $stable(command) && $stable(value))

    // a refused push only happens on a full queue
    `CDQ_ASSERT_NOW(a_full_refuse, clk, rst_n, rsp_valid && (status == ST_FULL), is_full)

    // a refused pop or empty peek leaves the queue empty
    `CDQ_ASSERT_NOW(a_empty_refuse, clk, rst_n, rsp_valid && (status == ST_EMPTY), is_empty && (occupancy == '0))

    // a stalled output word holds
    `CDQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data) && $stable(status))

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (.*);

### bench/tb_circular_double_ended_queue.sv
// self-checking bench for the circular double-ended queue: directed words, then random bursts
`timescale 1ns / 1ps

module tb_circular_double_ended_queue;

    import cdq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int RANDOM_WORDS = 1150;
    localparam int RUN_LIMIT_NS = 500_000;
    localparam int DRAIN_CYCLES = 20_000;
    localparam int HOLD_CYCLES  = 300;

    // command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    // kinds of random bursts
    localparam int FILL_RUN  = 0;
    localparam int DRAIN_RUN = 1;
    localparam int MIXED_RUN = 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [OCC_W-1:0]    occ;
        logic                full;
        logic                empty;
    } dq_result_t;

    typedef struct packed {
        bit         pinned;
        dq_result_t answer;
    } pinned_answer_t;

    typedef struct {
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] word;
        bit                 pinned;
        dq_result_t         answer;
    } script_row_t;

    // opening script: empty-queue answers, extremes, head wrap, last-word pop, no-op codes
    localparam int SCRIPT_LEN = 22;
    script_row_t opening_script [SCRIPT_LEN] = '{
        '{CMD_PEEK_FRONT, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b1}},
        '{CMD_PEEK_REAR,  32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b1}},
        '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0, 1'b0, 1'b1}},
        '{CMD_POP_REAR,   32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0, 1'b0, 1'b1}},
        '{CMD_UNDEF_LO,   32'hFFFF_FFFF, 1'b1, '{ST_DONE,  32'h0000_0000, 5'd0, 1'b0, 1'b1}},
        '{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{ST_DONE,  32'h0000_0000, 5'd1, 1'b0, 1'b0}},
        '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b0, '0},
        '{CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
        '{CMD_PEEK_REAR,  32'h0000_0000, 1'b0, '0},
        '{CMD_PUSH_REAR,  32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_PUSH_REAR,  32'h0000_0000, 1'b0, '0},
        '{CMD_UNDEF_HI,   32'h1234_5678, 1'b0, '0},
        '{CMD_PEEK_REAR,  32'h0000_0000, 1'b0, '0},
        '{CMD_POP_REAR,   32'h0000_0000, 1'b0, '0},
        '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
        '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{CMD_POP_REAR,   32'h0000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 5'd0, 1'b0, 1'b1}},
        '{CMD_PEEK_REAR,  32'h0000_0000, 1'b1, '{ST_EMPTY, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b1}},
        '{CMD_PUSH_REAR,  32'h0000_0001, 1'b0, '0},
        '{CMD_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
        '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_ready;
    logic        [CMD_W-1:0]   command   = CMD_PUSH_FRONT;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      rsp_valid;
    logic                      rsp_ready = 1'b0;
    logic        [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0] read_data;
    logic        [OCC_W-1:0]   occupancy;
    logic                      is_full;
    logic                      is_empty;

    // predictor state
    logic [VALUE_W-1:0] deque_slots [DEPTH];
    logic [PTR_W-1:0]   front_ptr = '0;
    logic [PTR_W-1:0]   rear_ptr  = '0;
    logic [OCC_W-1:0]   fill      = '0;

    dq_result_t     answers_due [$];
    pinned_answer_t pinned_answers [$];

    int  mismatch_count = 0;
    int  words_stored   = 0;
    int  pushes_refused = 0;
    int  words_removed  = 0;
    int  empty_refusals = 0;
    int  peeks_served   = 0;
    int  times_full     = 0;
    bit  sender_quiet   = 1'b0;
    bit  receiver_quiet = 1'b0;

    circular_double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (command),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .read_data (read_data),
        .occupancy (occupancy),
        .is_full   (is_full),
        .is_empty  (is_empty)
    );

    always #1 clk = ~clk;

    // deque behavior: updates the state copy and returns the answer word
    function automatic dq_result_t apply_deque_cmd(input logic [CMD_W-1:0] op,
                                                   input logic [VALUE_W-1:0] word);
        dq_result_t r;
        r = '0;
        r.status = ST_DONE;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (fill == DEPTH) begin
                    r.status = ST_FULL;
                    pushes_refused++;
                end else begin
                    // empty queue restarts both pointers at slot zero
                    if (fill == 0) begin
                        front_ptr = '0;
                        rear_ptr  = '0;
                    end else if (op == CMD_PUSH_FRONT) begin
                        front_ptr = front_ptr - 1'b1;
                    end else begin
                        rear_ptr = rear_ptr + 1'b1;
                    end
                    deque_slots[(op == CMD_PUSH_FRONT) ? front_ptr : rear_ptr] = word;
                    fill = fill + 1'b1;
                    words_stored++;
                    if (fill == DEPTH)
                        times_full++;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_refusals++;
                end else begin
                    // last word leaves the pointers where they are
                    if (fill > 1) begin
                        if (op == CMD_POP_FRONT)
                            front_ptr = front_ptr + 1'b1;
                        else
                            rear_ptr = rear_ptr - 1'b1;
                    end
                    fill = fill - 1'b1;
                    words_removed++;
                end
            end
            CMD_PEEK_FRONT, CMD_PEEK_REAR:
            begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    r.data   = '1;
                    empty_refusals++;
                end else begin
                    r.data = (op == CMD_PEEK_FRONT) ? deque_slots[front_ptr]
                                                    : deque_slots[rear_ptr];
                    peeks_served++;
                end
            end
            default:
            begin
            end
        endcase
        r.occ   = fill;
        r.full  = (fill == DEPTH);
        r.empty = (fill == 0);
        return r;
    endfunction

    // offer one word after a random gap and wait for it to be taken
    task automatic send_word(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
                             input bit pinned, input dq_result_t answer);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_quiet = !sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pinned_answers.push_back('{pinned, answer});
        cmd_valid <= 1'b1;
        command   <= op;
        value     <= word;
        do @(posedge clk); while (!cmd_ready);
    endtask

    // reset, directed script, random bursts, drain and verdict
    initial
    begin
        int               k;
        int               run_kind;
        int               run_left;
        int               pick;
        logic [CMD_W-1:0] op;
        logic [VALUE_W-1:0] word;
        run_kind = MIXED_RUN;
        run_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < SCRIPT_LEN; k++)
            send_word(opening_script[k].op, opening_script[k].word,
                      opening_script[k].pinned, opening_script[k].answer);

        // random bursts that lean toward filling, draining or mixing
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (run_left == 0) begin
                run_kind = $urandom_range(FILL_RUN, MIXED_RUN);
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick == 0)
                op = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
            else if (run_kind == FILL_RUN && pick < 85)
                op = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            else if (run_kind == DRAIN_RUN && pick < 85)
                op = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
            else
                op = $urandom_range(CMD_PUSH_FRONT, CMD_PEEK_REAR);
            case ($urandom_range(0, 7))
                0: word = 32'h7FFF_FFFF;
                1: word = 32'h8000_0000;
                2: word = 32'hFFFF_FFFF;
                3: word = 32'h0000_0000;
                default: word = $urandom();
            endcase
            send_word(op, word, 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        for (k = 0; k < DRAIN_CYCLES && answers_due.size() != 0; k++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (answers_due.size() != 0) begin
            mismatch_count += answers_due.size();
            $display("%0d expected words never came out", answers_due.size());
        end

        $display("covered %0d stored, %0d removed, %0d peeks, %0d refused full, %0d empty",
                 words_stored, words_removed, peeks_served, pushes_refused, empty_refusals);
        $display("queue reached full %0d times, %0d mismatches", times_full, mismatch_count);
        if (mismatch_count == 0)
            $display("circular_double_ended_queue: match");
        else
            $display("circular_double_ended_queue: mismatch");
        $finish;
    end

    // response side: random stalls plus two long hold-offs to back the block up
    initial
    begin
        int taken;
        int stall;
        taken = 0;
        wait (rst_n);
        forever begin
            if (taken == 60 || taken == 700) begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                receiver_quiet = !receiver_quiet;
            stall = receiver_quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            taken++;
        end
    end

    // predict on each taken command, compare each taken response
    always @(posedge clk)
    begin : watch
        pinned_answer_t pa;
        dq_result_t     want;
        if (rst_n) begin
            if (cmd_valid && cmd_ready) begin
                pa   = pinned_answers.pop_front();
                want = apply_deque_cmd(command, value);
                if (pa.pinned)
                    want = pa.answer;
                answers_due.push_back(want);
            end
            if (rsp_valid && rsp_ready) begin
                if (answers_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: status %0d data %h occ %0d full %b empty %b",
                                 status, read_data, occupancy, is_full, is_empty);
                end else begin
                    want = answers_due.pop_front();
                    if (status !== want.status || read_data !== want.data ||
                        occupancy !== want.occ || is_full !== want.full ||
                        is_empty !== want.empty) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("expected status %0d data %h occ %0d full %b empty %b",
                                     want.status, want.data, want.occ, want.full, want.empty);
                            $display("     got status %0d data %h occ %0d full %b empty %b",
                                     status, read_data, occupancy, is_full, is_empty);
                        end
                    end
                end
            end
        end
    end

    // hard stop in case the handshakes hang
    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d words outstanding", answers_due.size());
        $display("circular_double_ended_queue: mismatch");
        $finish;
    end

endmodule

### circular_double_ended_queue.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_double_ended_queue.sv
sv/cdq_checker.sv
bench/tb_circular_double_ended_queue.sv
